@@ hw/rtl/hsu_pkg.sv @@
// shared types, constants and sha-256 helper functions for the hmac-sha256 stream unit
// no dependencies; imported by every module of the block
package hsu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int APB_AW      = 5;
    localparam int KEY_WORDS   = 4;

    localparam logic [7:0]   PAD_IN  = 8'h36;
    localparam logic [7:0]   PAD_OUT = 8'h5c;
    localparam logic [31:0]  PAD_BIT = 32'h8000_0000;
    localparam logic [31:0]  OUTER_BITS = 32'd768;

    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       msg_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        word_last;
        logic        too_long;
    } t_out_item;

    typedef struct packed {
        logic         wr;
        logic [255:0] key;
    } t_key_ctl;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] k_round(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

@@ hw/rtl/hmac_sha256_stream_unit.sv @@
// top level of the hmac-sha256 stream unit
// depends on hsu_pkg, hsu_front, hsu_queue, hsu_back
//
// usage
//   input channel: one message byte per transaction (i_in.msg_byte), msg_last on the
//   final byte; valid/stall handshake, accepted when i_in_valid is high and o_in_stall low
//   output channel: four 64-bit big-endian digest words per message, word_last on the
//   fourth, too_long on all four if the message reached 2^61 bytes
//   apb port: key words 0 to 3 at byte addresses 0, 8, 16, 24; write only while idle
// timing
//   bytes enter a four-entry queue; the engine takes one byte a cycle while idle and
//   takes none while it compresses a full 64-byte block (one sha-256 round per cycle)
//   after the last byte the engine compresses one or two inner padding blocks, the
//   opad block and the outer block before the digest appears, then compresses the
//   ipad block of the next message
//   a key write while no message is open also starts an ipad compression
// reset
//   synchronous, active low; the key clears to zero and the ipad block is compressed
//   first, while queued bytes wait
// stalls
//   a stalled digest word holds in the output register; the engine keeps working on
//   the next message and waits only if its own digest is ready before the old one leaves
module hmac_sha256_stream_unit import hsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    input  t_in_item          i_in,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output t_out_item         o_out,
    input  logic              i_out_stall
);

    // queue between front end and engine
    logic     q_push;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    t_in_item q_in_item;
    t_in_item q_out_item;
    t_key_ctl key_ctl;

    hsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item),
        .o_key      (key_ctl)
    );

    hsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item),
        .i_pop   (q_pop)
    );

    // engine and output register
    hsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key_ctl),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ hw/rtl/hsu_front.sv @@
// front end: apb key registers and input byte acceptance into the queue
// depends on hsu_pkg
module hsu_front import hsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    input  t_in_item          i_in,
    output logic              o_in_stall,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_in_item          o_q_item,
    output t_key_ctl          o_key
);

    logic [63:0] r_key [KEY_WORDS];
    logic        wr_en;
    logic [1:0]  wr_idx;

    assign pready = 1'b1;
    assign wr_idx = paddr[APB_AW-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign prdata = r_key[wr_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_WORDS; i++) r_key[i] <= 64'd0;
        end else if (wr_en) begin
            r_key[wr_idx] <= pwdata;
        end
    end

    assign o_key.wr  = wr_en;
    assign o_key.key = {r_key[0], r_key[1], r_key[2], r_key[3]};

    // byte transactions go straight into the queue while it has room
    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign o_q_item   = i_in;

endmodule

@@ hw/rtl/hsu_queue.sv @@
// small fifo between the front end and the hash engine
// depends on hsu_pkg
module hsu_queue import hsu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_valid,
    output t_in_item o_item,
    input  logic     i_pop
);

    t_in_item            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

@@ hw/rtl/hsu_back.sv @@
// hash engine: block assembly, padding, one sha-256 round per cycle, output register
// depends on hsu_pkg
module hsu_back import hsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_key_ctl  i_key,
    input  logic      i_q_valid,
    input  t_in_item  i_q_item,
    output logic      o_q_pop,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        J_REKEY, J_MSG, J_PAD1, J_FIN, J_OPAD, J_OUTER
    } t_job;

    t_state       r_state;
    t_job         r_job;
    logic [5:0]   r_rnd;
    logic [31:0]  r_w    [16];
    logic [31:0]  r_v    [8];
    logic [31:0]  r_base [8];
    logic [31:0]  r_hw   [8];
    logic [60:0]  r_cnt;
    logic         r_ovf;
    logic         r_last_pend;
    logic         r_rekey;
    logic         r_ovalid;
    logic [1:0]   r_oidx;
    logic [255:0] r_dig;
    logic         r_oovf;

    logic [5:0]   pos;
    logic [60:0]  len_sum;
    logic [63:0]  len_bits;
    logic [31:0]  res     [8];
    logic [31:0]  ipad_w  [16];
    logic [31:0]  opad_w  [16];
    logic [31:0]  pad_w   [16];
    logic [31:0]  t1, t2, sched;
    logic [5:0]   bidx;

    assign pos      = r_cnt[5:0];
    assign len_sum  = r_cnt + 61'd64;
    assign len_bits = {len_sum, 3'b000};
    assign o_q_pop  = (r_state == S_IDLE) && !r_rekey && i_q_valid;

    always_comb begin
        for (int i = 0; i < 8; i++) res[i] = r_base[i] + r_v[i];
        for (int j = 0; j < 16; j++) begin
            if (j < 8) begin
                ipad_w[j] = i_key.key[32*(7-j) +: 32] ^ {4{PAD_IN}};
                opad_w[j] = i_key.key[32*(7-j) +: 32] ^ {4{PAD_OUT}};
            end else begin
                ipad_w[j] = {4{PAD_IN}};
                opad_w[j] = {4{PAD_OUT}};
            end
        end
        // marker byte at pos, zeros after it
        for (int j = 0; j < 16; j++) begin
            for (int k = 0; k < 4; k++) begin
                bidx = 6'(4*j + k);
                if (bidx < pos)       pad_w[j][8*(3-k) +: 8] = r_w[j][8*(3-k) +: 8];
                else if (bidx == pos) pad_w[j][8*(3-k) +: 8] = 8'h80;
                else                  pad_w[j][8*(3-k) +: 8] = 8'h00;
            end
        end
        t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + k_round(r_rnd) + r_w[0];
        t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        sched = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_REKEY;
            r_rnd       <= 6'd0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_last_pend <= 1'b0;
            r_rekey     <= 1'b1;
            r_ovalid    <= 1'b0;
            r_oidx      <= 2'd0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_dig  <= {r_dig[191:0], 64'd0};
                r_oidx <= r_oidx + 2'd1;
                if (r_oidx == 2'd3) r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (r_rekey) begin
                        r_job   <= J_REKEY;
                        r_rnd   <= 6'd0;
                        r_state <= S_COMP;
                        for (int j = 0; j < 16; j++) r_w[j] <= ipad_w[j];
                        for (int i = 0; i < 8; i++) begin
                            r_v[i]    <= SHA_IV[32*(7-i) +: 32];
                            r_base[i] <= SHA_IV[32*(7-i) +: 32];
                        end
                    end else if (i_q_valid) begin
                        r_w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= i_q_item.msg_byte;
                        r_cnt <= r_cnt + 61'd1;
                        if (&r_cnt) r_ovf <= 1'b1;
                        if (pos == 6'd63) begin
                            r_last_pend <= i_q_item.msg_last;
                            r_job       <= J_MSG;
                            r_rnd       <= 6'd0;
                            r_state     <= S_COMP;
                            for (int i = 0; i < 8; i++) begin
                                r_v[i]    <= r_hw[i];
                                r_base[i] <= r_hw[i];
                            end
                        end else if (i_q_item.msg_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    for (int j = 0; j < 14; j++) r_w[j] <= pad_w[j];
                    if (pos < 6'd56) begin
                        r_w[14] <= len_bits[63:32];
                        r_w[15] <= len_bits[31:0];
                        r_job   <= J_FIN;
                    end else begin
                        r_w[14] <= pad_w[14];
                        r_w[15] <= pad_w[15];
                        r_job   <= J_PAD1;
                    end
                    r_rnd   <= 6'd0;
                    r_state <= S_COMP;
                    for (int i = 0; i < 8; i++) begin
                        r_v[i]    <= r_hw[i];
                        r_base[i] <= r_hw[i];
                    end
                end
                S_COMP: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
                    r_w[15] <= sched;
                    r_rnd   <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_rnd <= 6'd0;
                    unique case (r_job)
                        J_REKEY: begin
                            for (int i = 0; i < 8; i++) r_hw[i] <= res[i];
                            r_state <= S_IDLE;
                        end
                        J_MSG: begin
                            for (int i = 0; i < 8; i++) r_hw[i] <= res[i];
                            r_state <= r_last_pend ? S_PAD : S_IDLE;
                        end
                        J_PAD1: begin
                            for (int j = 0; j < 14; j++) r_w[j] <= 32'd0;
                            r_w[14] <= len_bits[63:32];
                            r_w[15] <= len_bits[31:0];
                            for (int i = 0; i < 8; i++) begin
                                r_v[i]    <= res[i];
                                r_base[i] <= res[i];
                            end
                            r_job   <= J_FIN;
                            r_state <= S_COMP;
                        end
                        J_FIN: begin
                            // inner digest parks in the chaining registers
                            for (int i = 0; i < 8; i++) begin
                                r_hw[i]   <= res[i];
                                r_v[i]    <= SHA_IV[32*(7-i) +: 32];
                                r_base[i] <= SHA_IV[32*(7-i) +: 32];
                            end
                            for (int j = 0; j < 16; j++) r_w[j] <= opad_w[j];
                            r_job   <= J_OPAD;
                            r_state <= S_COMP;
                        end
                        J_OPAD: begin
                            for (int i = 0; i < 8; i++) begin
                                r_w[i]    <= r_hw[i];
                                r_v[i]    <= res[i];
                                r_base[i] <= res[i];
                            end
                            r_w[8] <= PAD_BIT;
                            for (int j = 9; j < 15; j++) r_w[j] <= 32'd0;
                            r_w[15] <= OUTER_BITS;
                            r_job   <= J_OUTER;
                            r_state <= S_COMP;
                        end
                        J_OUTER: begin
                            for (int i = 0; i < 8; i++) r_v[i] <= res[i];
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_dig    <= {r_v[0], r_v[1], r_v[2], r_v[3],
                                     r_v[4], r_v[5], r_v[6], r_v[7]};
                        r_ovalid <= 1'b1;
                        r_oidx   <= 2'd0;
                        r_oovf   <= r_ovf;
                        r_cnt    <= '0;
                        r_ovf    <= 1'b0;
                        r_job    <= J_REKEY;
                        r_rnd    <= 6'd0;
                        r_state  <= S_COMP;
                        for (int j = 0; j < 16; j++) r_w[j] <= ipad_w[j];
                        for (int i = 0; i < 8; i++) begin
                            r_v[i]    <= SHA_IV[32*(7-i) +: 32];
                            r_base[i] <= SHA_IV[32*(7-i) +: 32];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // a key write at this edge must win over a rekey started with the old key
            if (i_key.wr && (r_cnt == '0) && !r_ovf) begin
                r_rekey <= 1'b1;
            end else if (r_state == S_IDLE) begin
                r_rekey <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_out.digest_word = r_dig[255:192];
    assign o_out.word_last   = (r_oidx == 2'd3);
    assign o_out.too_long    = r_oovf;

    a_done_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> $past(r_state) == S_COMP && $past(r_rnd) == 6'd63)
        else $error("compression finished early");

    a_out_four_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ovalid) |-> $past(r_oidx) == 2'd3)
        else $error("digest dropped before fourth word");

    a_out_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_ovalid) |=> r_ovalid && r_state == S_COMP)
        else $error("digest handover missed");

    a_pad_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAD |-> $past(r_state) == S_IDLE || $past(r_state) == S_DONE)
        else $error("padding entered from wrong state");

endmodule
